// ===== hw/rtl/rbm_pkg.sv =====
// Shared codes, constants and types for the ROM bank mapper with DMA snoop.
package rbm_pkg;

    // Bus request codes
    localparam logic [1:0] REQ_CTRL_RD = 2'd0;
    localparam logic [1:0] REQ_CTRL_WR = 2'd1;
    localparam logic [1:0] REQ_DMA_WR  = 2'd2;
    localparam logic [1:0] REQ_MEM_RD  = 2'd3;

    // Result source codes
    localparam logic [1:0] SRC_NONE   = 2'd0;
    localparam logic [1:0] SRC_REG    = 2'd1;
    localparam logic [1:0] SRC_ROM    = 2'd2;
    localparam logic [1:0] SRC_DECOMP = 2'd3;

    // Control register indexes
    localparam logic [3:0] CREG_DMA_EN    = 4'd0;
    localparam logic [3:0] CREG_DECOMP_EN = 4'd1;
    localparam logic [3:0] CREG_SLOT0     = 4'd4;
    localparam logic [3:0] CREG_SLOT1     = 4'd5;
    localparam logic [3:0] CREG_SLOT2     = 4'd6;
    localparam logic [3:0] CREG_SLOT3     = 4'd7;

    // DMA channel register indexes
    localparam logic [3:0] DREG_SRC0 = 4'd2;
    localparam logic [3:0] DREG_SRC1 = 4'd3;
    localparam logic [3:0] DREG_SRC2 = 4'd4;
    localparam logic [3:0] DREG_CNT0 = 4'd5;
    localparam logic [3:0] DREG_CNT1 = 4'd6;

    localparam logic [7:0]  BANK_WR_MASK = 8'h8f;
    localparam logic [23:0] ROM_REG_BASE = 24'h004800;
    localparam int          MAX_CHANNELS = 8;

    // Result of the channel address compare
    typedef struct packed {
        logic       hit;
        logic [7:0] sel;   // one-hot, lowest matching channel
    } match_t;

endpackage

// ===== hw/rtl/rbm_chan_match.sv =====
// Priority address compare across the enabled DMA channels.
module rbm_chan_match #(
    parameter int CHANNELS = 8
) (
    input  logic [7:0]      dma_en,
    input  logic [7:0]      decomp_en,
    input  logic [23:0]     chan_src [CHANNELS],
    input  logic [23:0]     address,
    output rbm_pkg::match_t match
);
    import rbm_pkg::*;

    logic [7:0] eq;

    // Compare every channel in parallel
    always_comb begin
        eq = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            eq[i] = dma_en[i] && decomp_en[i] && (chan_src[i] == address);
        end
    end

    // Keep only the lowest hit
    always_comb begin
        match.hit = |eq;
        match.sel = eq & (~eq + 8'd1);
    end

endmodule

// ===== hw/rtl/rom_bank_mapper_with_dma_snoop_top.sv =====
// Top level of the ROM bank mapper with DMA snoop.
//
// One bus access enters per word on the s_ channel and gives exactly one result
// word on the m_ channel. Control reads return the DMA-enable mask, the
// decompress-enable mask, one of the four bank slots or, for other indexes, a
// ROM address at ROM_REG_BASE; control writes set them (bank slots keep bits 7
// and 3..0). DMA register writes are snooped so each channel's 24-bit source
// address and 16-bit byte count are known. Low-half memory reads map to linear
// ROM addresses; high-half reads go through the bank slots unless an enabled
// channel's source address matches, in which case the byte comes from the
// decompressor, the channel count steps down, and the stream is closed when the
// count reaches zero (a count of 0 means 65536 bytes). Rate: one word per clock
// while m_ready holds. An accepted word waits in the input register (eight-way
// address compare, count decrement), then moves into the result register. Ready
// drops only when the result register is full and m_ready is low.
module rom_bank_mapper_with_dma_snoop_top #(
    parameter int CHANNELS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [23:0] s_bus_address,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_source,
    output logic [7:0]  m_read_data,
    output logic [23:0] m_rom_address,
    output logic        m_decomp_start,
    output logic        m_stream_done
);
    import rbm_pkg::*;

    // Input register
    logic        in_valid_reg;
    logic [1:0]  in_req_reg;
    logic [23:0] in_addr_reg;
    logic [7:0]  in_wdata_reg;

    // Block state
    logic [7:0]  dma_en_reg;
    logic [7:0]  decomp_en_reg;
    logic [7:0]  bank_slot_reg [4];
    logic [23:0] chan_src_reg [CHANNELS];
    logic [15:0] chan_cnt_reg [CHANNELS];
    logic        stream_active_reg;

    // Result register
    logic        out_valid_reg;
    logic [1:0]  out_source_reg;
    logic [7:0]  out_data_reg;
    logic [23:0] out_rom_reg;
    logic        out_start_reg;
    logic        out_done_reg;

    logic        advance;
    logic [3:0]  sel;
    logic [2:0]  chan;
    logic        high_half;
    logic        fold_bit21;
    match_t      match;
    logic        last_byte;
    logic        decomp_hit;

    logic [1:0]  res_source;
    logic [7:0]  res_data;
    logic [23:0] res_rom;
    logic        res_start;
    logic        res_done;

    // Move a word forward whenever the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign sel       = in_addr_reg[3:0];
    assign chan      = in_addr_reg[6:4];
    assign high_half = in_addr_reg[22];

    // Bit 21 folds away in the low half when slot 1 (or slot 3 above bit 23) asks for it
    assign fold_bit21 = in_addr_reg[23] ? bank_slot_reg[3][7] : bank_slot_reg[1][7];

    rbm_chan_match #(
        .CHANNELS(CHANNELS)
    ) u_match (
        .dma_en   (dma_en_reg),
        .decomp_en(decomp_en_reg),
        .chan_src (chan_src_reg),
        .address  (in_addr_reg),
        .match    (match)
    );

    assign decomp_hit = (in_req_reg == REQ_MEM_RD) && high_half && match.hit;

    // The matching channel is on its last byte when its count stands at one
    always_comb begin
        last_byte = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (match.sel[i] && (chan_cnt_reg[i] == 16'd1)) begin
                last_byte = 1'b1;
            end
        end
    end

    // Result word for the access in the input register
    always_comb begin
        res_source = SRC_NONE;
        res_data   = '0;
        res_rom    = '0;
        res_start  = 1'b0;
        res_done   = 1'b0;
        unique case (in_req_reg)
            REQ_CTRL_RD: begin
                unique case (sel) inside
                    CREG_DMA_EN: begin
                        res_source = SRC_REG;
                        res_data   = dma_en_reg;
                    end
                    CREG_DECOMP_EN: begin
                        res_source = SRC_REG;
                        res_data   = decomp_en_reg;
                    end
                    [CREG_SLOT0:CREG_SLOT3]: begin
                        res_source = SRC_REG;
                        res_data   = bank_slot_reg[sel[1:0]];
                    end
                    default: begin
                        res_source = SRC_ROM;
                        res_rom    = ROM_REG_BASE | {20'd0, sel};
                    end
                endcase
            end
            REQ_CTRL_WR, REQ_DMA_WR: begin
                res_source = SRC_NONE;
            end
            REQ_MEM_RD: begin
                if (!high_half) begin
                    res_source = SRC_ROM;
                    res_rom    = {3'd0, in_addr_reg[21] && !fold_bit21,
                                  in_addr_reg[20:16], in_addr_reg[14:0]};
                end else if (match.hit) begin
                    res_source = SRC_DECOMP;
                    res_start  = !stream_active_reg;
                    res_done   = last_byte;
                end else begin
                    res_source = SRC_ROM;
                    res_rom    = {bank_slot_reg[in_addr_reg[21:20]][3:0], in_addr_reg[19:0]};
                end
            end
            default: begin
                res_source = SRC_NONE;
            end
        endcase
    end

    // Input register: take a word whenever there is room
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_req_reg   <= s_req_type;
            in_addr_reg  <= s_bus_address;
            in_wdata_reg <= s_write_data;
        end
    end

    // Control registers and stream state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dma_en_reg        <= '0;
            decomp_en_reg     <= '0;
            stream_active_reg <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                bank_slot_reg[k] <= 8'(k);
            end
        end else if (advance) begin
            if (in_req_reg == REQ_CTRL_WR) begin
                unique case (sel) inside
                    CREG_DMA_EN:             dma_en_reg    <= in_wdata_reg;
                    CREG_DECOMP_EN:          decomp_en_reg <= in_wdata_reg;
                    [CREG_SLOT0:CREG_SLOT3]: bank_slot_reg[sel[1:0]] <= in_wdata_reg & BANK_WR_MASK;
                    default: ;
                endcase
            end
            if (decomp_hit) begin
                stream_active_reg <= !last_byte;
                if (last_byte) begin
                    decomp_en_reg <= decomp_en_reg & ~match.sel;
                end
            end
        end
    end

    // Channel source and count: snooped writes and decrement on a decompressor byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                chan_src_reg[i] <= '0;
                chan_cnt_reg[i] <= '0;
            end
        end else if (advance) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if ((in_req_reg == REQ_DMA_WR) && (chan == 3'(i))) begin
                    unique case (sel)
                        DREG_SRC0: chan_src_reg[i][7:0]   <= in_wdata_reg;
                        DREG_SRC1: chan_src_reg[i][15:8]  <= in_wdata_reg;
                        DREG_SRC2: chan_src_reg[i][23:16] <= in_wdata_reg;
                        DREG_CNT0: chan_cnt_reg[i][7:0]   <= in_wdata_reg;
                        DREG_CNT1: chan_cnt_reg[i][15:8]  <= in_wdata_reg;
                        default: ;
                    endcase
                end
                if (decomp_hit && match.sel[i]) begin
                    chan_cnt_reg[i] <= chan_cnt_reg[i] - 16'd1;
                end
            end
        end
    end

    // Result register: hold until taken, refill on advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_source_reg <= res_source;
            out_data_reg   <= res_data;
            out_rom_reg    <= res_rom;
            out_start_reg  <= res_start;
            out_done_reg   <= res_done;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_source       = out_source_reg;
    assign m_read_data    = out_data_reg;
    assign m_rom_address  = out_rom_reg;
    assign m_decomp_start = out_start_reg;
    assign m_stream_done  = out_done_reg;

endmodule
